// ----- sv/mono_bitmap_pixel_expander_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the mono bitmap pixel expander
// Clocked on clk, disabled while rst_n is low. Define NO_ASSERTIONS to drop.
// ---------------------------------------------------------------------------
`ifndef MONO_BITMAP_PIXEL_EXPANDER_ASSERT_SVH
`define MONO_BITMAP_PIXEL_EXPANDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Plain property, may hold its own implication
`define MBPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition this cycle implies outcome next cycle
`define MBPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBPE_ASSERT(label, prop, msg)
`define MBPE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/mbpe_pkg.sv -----
// ---------------------------------------------------------------------------
// mbpe_pkg
// Shared widths, register indexes and lane types of the pixel expander.
// ---------------------------------------------------------------------------
package mbpe_pkg;

    // Dimension registers are 13 bits wide, limit 4096
    localparam int DIM_W       = 13;
    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    localparam int COORD_W     = 12;
    localparam int COLOUR_W    = 24;
    localparam int ORIGIN_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 12;
    localparam int POS_W       = 10;
    // screen coordinate before clipping: 13 bit magnitude plus 16 bit offset
    localparam int SCR_W       = 18;

    localparam int LANES       = 8;
    localparam int LANE_IDX_W  = 3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_ORIGIN_X      = 3'd2,
        CFG_ORIGIN_Y      = 3'd3,
        CFG_DRAW_COLOUR   = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6
    } cfg_index_t;

    // One lane's verdict on its pixel
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] sx;
    } lane_hit_t;

    // Emitter status seen by the input stage
    typedef struct packed {
        logic busy;
        logic can_load;
    } emit_status_t;

endpackage

// ----- sv/mbpe_if.sv -----
// ---------------------------------------------------------------------------
// mbpe channel interfaces
// Valid/ready channels for image bytes in and pixel writes out.
// ---------------------------------------------------------------------------
interface mbpe_byte_if
    import mbpe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] image_byte;

    modport source (output valid, output image_byte, input ready);
    modport sink   (input valid, input image_byte, output ready);
endinterface

interface mbpe_pixel_if
    import mbpe_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last_of_byte;

    modport source (output valid, output pixel_x, output pixel_y,
                    output pixel_colour, output last_of_byte, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input pixel_colour, input last_of_byte, output ready);
endinterface

// ----- sv/mbpe_lane.sv -----
// ---------------------------------------------------------------------------
// mbpe_lane
// Decides for one bit of a byte whether it yields a clipped pixel write.
// ---------------------------------------------------------------------------
module mbpe_lane
    import mbpe_pkg::*;
(
    input  logic                  pixel_bit,
    input  logic                  active,
    input  logic                  row_visible,
    input  logic [POS_W-1:0]      byte_pos,
    input  logic [LANE_IDX_W-1:0] lane_idx,
    input  logic [DIM_W-1:0]      image_width,
    input  logic [DIM_W-1:0]      screen_width,
    input  logic [ORIGIN_W-1:0]   origin_x,
    output lane_hit_t             result
);

    logic [DIM_W-1:0]        x;
    logic signed [SCR_W-1:0] sx;
    logic                    in_image;
    logic                    on_screen;

    // image column of this bit, then screen column
    assign x  = {byte_pos, lane_idx};
    assign sx = $signed({{(SCR_W-DIM_W){1'b0}}, x})
              + $signed({{(SCR_W-ORIGIN_W){origin_x[ORIGIN_W-1]}}, origin_x});

    assign in_image  = x < image_width;
    assign on_screen = !sx[SCR_W-1]
                     && (sx < $signed({{(SCR_W-DIM_W){1'b0}}, screen_width}));

    assign result.hit = pixel_bit && active && row_visible && in_image && on_screen;
    assign result.sx  = sx[COORD_W-1:0];

endmodule

// ----- sv/mbpe_emit.sv -----
// ---------------------------------------------------------------------------
// mbpe_emit
// Merges the lane verdicts of one byte and sends its pixels one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module mbpe_emit
    import mbpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lane_hit_t           hits [LANES],
    input  logic [COORD_W-1:0]  sy,
    input  logic [COLOUR_W-1:0] colour,
    output emit_status_t        status,
    mbpe_pixel_if.source        pixel
);

    logic [LANES-1:0]   mask_reg;
    logic [LANES-1:0]   mask_next;
    logic [COORD_W-1:0] sx_reg [LANES];
    logic [COORD_W-1:0] sy_reg;

    logic [LANE_IDX_W-1:0] sel;
    logic [LANES-1:0]      first_oh;
    logic [LANES-1:0]      remaining;
    logic                  fire;
    logic                  last;

    // leftmost pending pixel: lowest lane index still set
    always_comb
    begin
        sel = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = i[LANE_IDX_W-1:0];
            end
        end
    end

    assign first_oh  = mask_reg & (~mask_reg + {{(LANES-1){1'b0}}, 1'b1});
    assign remaining = mask_reg & ~first_oh;
    assign last      = remaining == '0;
    assign fire      = pixel.valid && pixel.ready;

    assign status.busy     = mask_reg != '0;
    assign status.can_load = !status.busy || (fire && last);

    // output word straight from the held byte
    assign pixel.valid        = status.busy;
    assign pixel.pixel_x      = sx_reg[sel];
    assign pixel.pixel_y      = sy_reg;
    assign pixel.pixel_colour = colour;
    assign pixel.last_of_byte = last;

    // pending mask: new byte, next pixel, or hold
    always_comb
    begin
        mask_next = mask_reg;
        priority if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mask_next[i] = hits[i].hit;
            end
        end
        else if (fire)
        begin
            mask_next = remaining;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // coordinates, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                sx_reg[i] <= hits[i].sx;
            end
            sy_reg <= sy;
        end
    end

endmodule

// ----- sv/mono_bitmap_pixel_expander.sv -----
// ---------------------------------------------------------------------------
// mono_bitmap_pixel_expander
// Expands 1 bit per pixel bottom-up bitmap bytes into clipped pixel writes.
// ---------------------------------------------------------------------------
// Usage:
//   byte_chan takes the stored pixel bytes in file order, row padding
//   included; pixel_chan gives one pixel write word per set, visible bit,
//   leftmost first, with last_of_byte on the final write of each byte.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
// A taken byte passes the input stage register and then the emitter's
//   pending mask register before its first pixel write shows.
// The single pixel output port sets the throughput: a byte holds the
//   emitter until its last pixel is sent. Bytes yielding nothing, padding
//   included, pass at one per cycle while the emitter is free.
// A byte waits in the input stage while the emitter still sends the
//   previous one, so the next byte is taken while a word is stalled.
// When the receiver stalls, the current word holds and the input stage
//   fills and then drops ready.
// Reset clears the row and byte counters, both pipeline stages and all
//   registers to their defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module mono_bitmap_pixel_expander
    import mbpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mbpe_byte_if.sink              byte_chan,
    mbpe_pixel_if.source           pixel_chan
);

`include "mono_bitmap_pixel_expander_assert.svh"

    // Configuration, stored already clamped
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [DIM_W-1:0]    sw_reg;
    logic [DIM_W-1:0]    sh_reg;

    logic [DIM_W-1:0]    cfg_dim;
    logic [DIM_W-1:0]    cfg_dim_img;
    logic [DIM_W-1:0]    cfg_dim_scr;

    // Counters and input stage
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;
    logic [POS_W-1:0]  byte_in_row_reg;
    logic [POS_W-1:0]  byte_in_row_next;

    logic              sta_valid_reg;
    logic [BYTE_W-1:0] sta_data_reg;
    logic [POS_W-1:0]  sta_pos_reg;
    logic [ROW_W-1:0]  sta_row_reg;
    logic              sta_active_reg;

    logic [DIM_W-1:0]  width_plus;
    logic [POS_W-1:0]  row_used_bytes;
    logic [POS_W-1:0]  stride_sum;
    logic [POS_W-1:0]  stride;
    logic [ROW_W-1:0]  row_eff;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  pos_inc;
    logic [DIM_W-1:0]  row_inc;
    logic              in_fire;
    logic              sta_advance;

    logic [DIM_W-1:0]        flip_row;
    logic signed [SCR_W-1:0] sy;
    logic                    row_visible;

    lane_hit_t    hits [LANES];
    emit_status_t emit_status;

    // clamp of a written dimension
    assign cfg_dim     = cfg_data[DIM_W-1:0];
    assign cfg_dim_scr = (cfg_dim > MAX_DIM) ? MAX_DIM : cfg_dim;
    assign cfg_dim_img = (cfg_dim == '0) ? {{(DIM_W-1){1'b0}}, 1'b1} : cfg_dim_scr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 13'd1;
            height_reg   <= 13'd1;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            colour_reg   <= 24'hFFFFFF;
            sw_reg       <= 13'd640;
            sh_reg       <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg    <= cfg_dim_img;
                CFG_IMAGE_HEIGHT:  height_reg   <= cfg_dim_img;
                CFG_ORIGIN_X:      origin_x_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:      origin_y_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_DRAW_COLOUR:   colour_reg   <= cfg_data[COLOUR_W-1:0];
                CFG_SCREEN_WIDTH:  sw_reg       <= cfg_dim_scr;
                CFG_SCREEN_HEIGHT: sh_reg       <= cfg_dim_scr;
                default:           ;
            endcase
        end
    end

    // row geometry: valid bytes, stride padded to four
    assign width_plus     = width_reg + 13'd7;
    assign row_used_bytes = width_plus[DIM_W-1:3];
    assign stride_sum     = row_used_bytes + 10'd3;
    assign stride         = {stride_sum[POS_W-1:2], 2'b00};

    // counters restart if a register change left them out of range
    assign row_eff = ({1'b0, row_count_reg} >= height_reg) ? '0 : row_count_reg;
    assign pos_eff = (byte_in_row_reg >= stride) ? '0 : byte_in_row_reg;
    assign pos_inc = pos_eff + 10'd1;
    assign row_inc = {1'b0, row_eff} + 13'd1;

    always_comb
    begin
        byte_in_row_next = pos_inc;
        row_count_next   = row_eff;
        if (pos_inc >= stride)
        begin
            byte_in_row_next = '0;
            row_count_next   = (row_inc >= height_reg) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    // input handshake
    assign sta_advance     = sta_valid_reg && emit_status.can_load;
    assign byte_chan.ready = !sta_valid_reg || sta_advance;
    assign in_fire         = byte_chan.valid && byte_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= '0;
            byte_in_row_reg <= '0;
            sta_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                row_count_reg   <= row_count_next;
                byte_in_row_reg <= byte_in_row_next;
            end
            if (in_fire)
            begin
                sta_valid_reg <= 1'b1;
            end
            else if (sta_advance)
            begin
                sta_valid_reg <= 1'b0;
            end
        end
    end

    // input stage word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sta_data_reg   <= byte_chan.image_byte;
            sta_pos_reg    <= pos_eff;
            sta_row_reg    <= row_eff;
            sta_active_reg <= pos_eff < row_used_bytes;
        end
    end

    // screen row, shared by all lanes: rows arrive bottom-up
    assign flip_row    = height_reg - 13'd1 - {1'b0, sta_row_reg};
    assign sy          = $signed({{(SCR_W-DIM_W){1'b0}}, flip_row})
                       + $signed({{(SCR_W-ORIGIN_W){origin_y_reg[ORIGIN_W-1]}},
                                  origin_y_reg});
    assign row_visible = !sy[SCR_W-1]
                       && (sy < $signed({{(SCR_W-DIM_W){1'b0}}, sh_reg}));

    // one lane per bit, lane 0 takes bit 7
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        mbpe_lane u_lane (
            .pixel_bit    (sta_data_reg[LANES-1-i]),
            .active       (sta_active_reg),
            .row_visible  (row_visible),
            .byte_pos     (sta_pos_reg),
            .lane_idx     (LANE_IDX_W'(i)),
            .image_width  (width_reg),
            .screen_width (sw_reg),
            .origin_x     (origin_x_reg),
            .result       (hits[i])
        );
    end

    mbpe_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (sta_advance),
        .hits   (hits),
        .sy     (sy[COORD_W-1:0]),
        .colour (colour_reg),
        .status (emit_status),
        .pixel  (pixel_chan)
    );

    // Assertions
    `MBPE_ASSERT_NEXT(a_more_after_not_last,
        pixel_chan.valid && pixel_chan.ready && !pixel_chan.last_of_byte,
        pixel_chan.valid, "pixels of a byte ended before its last word")
    `MBPE_ASSERT_NEXT(a_idle_after_last,
        pixel_chan.valid && pixel_chan.ready && pixel_chan.last_of_byte && !sta_advance,
        !pixel_chan.valid, "pixel word appeared without a new byte")
    `MBPE_ASSERT_NEXT(a_stage_holds,
        sta_valid_reg && !sta_advance, sta_valid_reg, "input stage dropped a byte")
    `MBPE_ASSERT(a_load_only_when_free,
        sta_advance |-> (!emit_status.busy || (pixel_chan.ready && pixel_chan.last_of_byte)),
        "byte loaded over pending pixels")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: mono bitmap pixel expander testbench
// Streams 1 bit per pixel bitmap bytes through the expander under several
// register settings, predicts every clipped pixel write, and checks each
// output word in order against the prediction.
// ---------------------------------------------------------------------------
module tb_top;
    import mbpe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    // random phases start until this many bytes are sent, directed ones included
    localparam int RAND_BYTES  = 150;

    typedef struct packed {
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } pixel_word_t;

    logic clk;
    logic rst_n = 1'b0;

    // testbench side of the ports, known from time zero
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   byte_valid  = 1'b0;
    logic [BYTE_W-1:0]      drv_byte    = '0;
    logic                   pixel_ready = 1'b0;

    mbpe_byte_if  byte_bus ();
    mbpe_pixel_if pixel_bus ();

    assign byte_bus.valid      = byte_valid;
    assign byte_bus.image_byte = drv_byte;
    assign pixel_bus.ready     = pixel_ready;

    mono_bitmap_pixel_expander u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_chan  (byte_bus),
        .pixel_chan (pixel_bus)
    );

    // predictor copy of the registers and counters
    logic [DIM_W-1:0]           img_w    = 13'd1;
    logic [DIM_W-1:0]           img_h    = 13'd1;
    logic signed [ORIGIN_W-1:0] org_x    = '0;
    logic signed [ORIGIN_W-1:0] org_y    = '0;
    logic [COLOUR_W-1:0]        colour   = 24'hFFFFFF;
    logic [DIM_W-1:0]           scr_w    = 13'd640;
    logic [DIM_W-1:0]           scr_h    = 13'd480;
    int unsigned                cur_row  = 0;
    int unsigned                cur_pos  = 0;

    pixel_word_t       pixel_expect[$];
    logic [BYTE_W-1:0] pending_bytes[$];
    int                bytes_pushed   = 0;
    int                bytes_taken    = 0;
    int                mismatch_count = 0;
    logic              byte_taken     = 1'b0;

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall state
    int   stall_mode = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;

    int cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lowest);
        if (v < lowest)
            return lowest;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // Predict the pixel writes of one stored byte and advance the counters
    function automatic void expand_byte(logic [BYTE_W-1:0] data);
        int unsigned w, h, sw, sh, row_bytes, stride, x;
        int          sx, sy, hits;
        pixel_word_t word;
        w         = clamp_dim(img_w, 1);
        h         = clamp_dim(img_h, 1);
        sw        = clamp_dim(scr_w, 0);
        sh        = clamp_dim(scr_h, 0);
        row_bytes = (w + 7) / 8;
        stride    = (row_bytes + 3) & ~32'd3;
        hits      = 0;
        // counters left out of range by a register change restart
        if (cur_row >= h)
            cur_row = 0;
        if (cur_pos >= stride)
            cur_pos = 0;
        if (cur_pos < row_bytes)
        begin
            // rows are stored bottom-up
            sy = int'(h) - 1 - int'(cur_row) + int'(org_y);
            for (int b = 0; b < 8; b++)
            begin
                x = cur_pos * 8 + b;
                if (x >= w)
                    break;
                sx = int'(x) + int'(org_x);
                if (data[7-b] && sx >= 0 && sx < int'(sw) && sy >= 0 && sy < int'(sh))
                begin
                    word.px     = sx[COORD_W-1:0];
                    word.py     = sy[COORD_W-1:0];
                    word.colour = colour;
                    word.last   = 1'b0;
                    pixel_expect.push_back(word);
                    hits++;
                end
            end
            if (hits != 0)
                pixel_expect[pixel_expect.size()-1].last = 1'b1;
        end
        cur_pos++;
        if (cur_pos >= stride)
        begin
            cur_pos = 0;
            cur_row++;
            if (cur_row >= h)
                cur_row = 0;
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Byte driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && !byte_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left   <= gap_left - 1;
                byte_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                byte_valid <= 1'b1;
                drv_byte   <= pending_bytes.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Receiver ready: one long hold on request, otherwise a changing pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                pixel_ready <= 1'b0;
                hold_left   <= hold_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                pixel_ready <= 1'b0;
                hold_left   <= LONG_HOLD;
                hold_done   <= 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    stall_left <= $urandom_range(16, 96);
                end
                else
                    stall_left <= stall_left - 1;
                case (stall_mode)
                    0: pixel_ready <= 1'b1;
                    1: pixel_ready <= 1'($urandom_range(0, 1));
                    2: pixel_ready <= ($urandom_range(0, 3) != 0);
                    default: pixel_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Monitor: predict on each taken byte, check each pixel word
    always @(posedge clk)
    begin
        pixel_word_t want;
        byte_taken <= byte_valid && byte_bus.ready;
        if (rst_n && byte_valid && byte_bus.ready)
        begin
            expand_byte(drv_byte);
            bytes_taken++;
        end
        if (rst_n && pixel_bus.valid && pixel_ready)
        begin
            if (pixel_expect.size() == 0)
                report_mismatch($sformatf("unexpected pixel word x=%0d y=%0d",
                                          pixel_bus.pixel_x, pixel_bus.pixel_y));
            else
            begin
                want = pixel_expect.pop_front();
                if (pixel_bus.pixel_x !== want.px)
                    report_mismatch($sformatf("pixel_x %0d, want %0d",
                                              pixel_bus.pixel_x, want.px));
                if (pixel_bus.pixel_y !== want.py)
                    report_mismatch($sformatf("pixel_y %0d, want %0d",
                                              pixel_bus.pixel_y, want.py));
                if (pixel_bus.pixel_colour !== want.colour)
                    report_mismatch($sformatf("pixel_colour %h, want %h",
                                              pixel_bus.pixel_colour, want.colour));
                if (pixel_bus.last_of_byte !== want.last)
                    report_mismatch($sformatf("last_of_byte %b, want %b at x=%0d y=%0d",
                                              pixel_bus.last_of_byte, want.last,
                                              want.px, want.py));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, int value);
        logic [CFG_DATA_W-1:0] data;
        case (idx)
            CFG_ORIGIN_X, CFG_ORIGIN_Y: data = CFG_DATA_W'(value & 'hFFFF);
            CFG_DRAW_COLOUR:            data = CFG_DATA_W'(value & 'hFFFFFF);
            default:                    data = CFG_DATA_W'(value & 'h1FFF);
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:   img_w  = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:  img_h  = data[DIM_W-1:0];
            CFG_ORIGIN_X:      org_x  = data[ORIGIN_W-1:0];
            CFG_ORIGIN_Y:      org_y  = data[ORIGIN_W-1:0];
            CFG_DRAW_COLOUR:   colour = data;
            CFG_SCREEN_WIDTH:  scr_w  = data[DIM_W-1:0];
            CFG_SCREEN_HEIGHT: scr_h  = data[DIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(int w, int h, int ox, int oy, int col, int sw, int sh);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_DRAW_COLOUR, col);
        write_reg(CFG_SCREEN_WIDTH, sw);
        write_reg(CFG_SCREEN_HEIGHT, sh);
    endtask

    task automatic queue_byte(logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_pushed++;
    endtask

    // Hold off until every byte is taken and every pixel word has arrived
    task automatic wait_drain();
        while (bytes_taken != bytes_pushed || pixel_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_pixels();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80 >> $urandom_range(0, 7);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int  w, h, ox, oy, sw, sh, stride, total, images;
        bit  noise, first_phase;
        first_phase = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: 1x1 image, one valid byte then three padding bytes
        queue_byte(8'h80);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h7F);
        wait_drain();

        // 13 wide, 2 rows on an 8x2 screen: bottom row clipped, tail bits skipped
        load_config(13, 2, -3, 1, 'h123456, 8, 2);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'hAA);
        queue_byte(8'h55);
        queue_byte(8'hE1);
        queue_byte(8'hFF);
        queue_byte(8'h12);
        queue_byte(8'h00);
        wait_drain();

        // Oversize registers saturate; pixels land at the far screen corner
        load_config(8191, 8191, 4032, 0, 'hFFFFFF, 8191, 8191);
        repeat (8) queue_byte(8'hFF);
        wait_drain();

        // Zero sizes, extreme origins, empty screen: counters restart, nothing drawn
        load_config(0, 0, -32768, 32767, 0, 0, 0);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        wait_drain();

        // 1x1 screen at origin: one pixel after the remaining padding
        load_config(0, 0, 0, 0, 0, 1, 1);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        wait_drain();

        // Random phases, mostly whole images with random content
        while (bytes_pushed < RAND_BYTES)
        begin
            noise = ($urandom_range(0, 4) == 0);
            if (first_phase)
            begin
                w  = 32;
                h  = 4;
                ox = 0;
                oy = 0;
                sw = 640;
                sh = 480;
            end
            else
            begin
                w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
                h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 6);
                ox = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) - 32768
                                                 : $urandom_range(0, 40) - 16;
                oy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) - 32768
                                                 : $urandom_range(0, 12) - 4;
                case ($urandom_range(0, 9))
                    0: sw = 0;
                    1: sw = $urandom_range(0, 8191);
                    2, 3: sw = 640;
                    default: sw = $urandom_range(1, 80);
                endcase
                case ($urandom_range(0, 9))
                    0: sh = 0;
                    1: sh = $urandom_range(0, 8191);
                    2, 3: sh = 480;
                    default: sh = $urandom_range(1, 12);
                endcase
                if (w == 0 || w > 64 || h == 0 || h > 6)
                    noise = 1'b1;
            end
            load_config(w, h, ox, oy, $urandom_range(0, 'hFFFFFF), sw, sh);

            if (first_phase)
                hold_req = 1'b1;

            if (noise && !first_phase)
            begin
                total = $urandom_range(1, 20);
                for (int i = 0; i < total; i++)
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                stride = ((w + 7) / 8 + 3) & ~3;
                images = $urandom_range(1, 2);
                total  = stride * h * images;
                for (int i = 0; i < total; i++)
                begin
                    // sender sometimes pauses mid-phase until the block has drained
                    if (i == total / 2 && $urandom_range(0, 3) == 0)
                        wait_drain();
                    queue_byte(pick_pixels());
                end
            end
            first_phase = 1'b0;
            wait_drain();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mbpe_pkg.sv
sv/mbpe_if.sv
sv/mbpe_lane.sv
sv/mbpe_emit.sv
sv/mono_bitmap_pixel_expander.sv
sim/tb_top.sv
